/* design/sbl_pkg.sv */
// Package for the six-bit label decoder: item, result and job types,
// code constants and the symbol shift table. No dependencies.
package sbl_pkg;

    localparam logic [5:0] CODE_TERM  = 6'h3F;
    localparam logic [5:0] CODE_SHIFT = 6'h1C;
    localparam logic [5:0] CODE_ZLAST = 6'h1A;
    localparam logic [5:0] CODE_D0    = 6'h20;
    localparam logic [5:0] CODE_D9    = 6'h29;
    localparam logic [5:0] SYM_COUNT  = 6'd17;
    localparam logic [6:0] ASCII_SPACE = 7'h20;
    localparam int         JOB_SLOTS  = 5;
    localparam int         MARK_SLOT  = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_label;
        logic       data_end;
    } t_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       is_char;
        logic       last;
    } t_result;

    // slots 0..3 carry characters in order, slot 4 the end-of-label marker
    typedef struct packed {
        logic [JOB_SLOTS-1:0]      vld;
        logic [JOB_SLOTS-2:0][6:0] chr;
    } t_job;

    function automatic logic [6:0] f_symbol(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'd0:    ch = 7'h20;
            6'd1:    ch = 7'h40;
            6'd2:    ch = 7'h21;
            6'd3:    ch = 7'h22;
            6'd4:    ch = 7'h23;
            6'd5:    ch = 7'h24;
            6'd6:    ch = 7'h25;
            6'd7:    ch = 7'h26;
            6'd8:    ch = 7'h27;
            6'd9:    ch = 7'h28;
            6'd10:   ch = 7'h29;
            6'd11:   ch = 7'h2A;
            6'd12:   ch = 7'h2B;
            6'd13:   ch = 7'h2C;
            6'd14:   ch = 7'h2D;
            6'd15:   ch = 7'h2E;
            6'd16:   ch = 7'h2F;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

/* design/sbl_front.sv */
// Front end: takes bytes, assembles 24-bit groups, tracks shift and end
// state and turns each byte into one job of up to five results. Uses sbl_pkg.
module sbl_front
    import sbl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_q_full,
    output logic  o_full,
    output logic  o_q_wr,
    output t_job  o_q_job
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_pos, n_pos;
    logic        r_shift, n_shift;
    logic        r_done, n_done;
    t_job        job;
    logic        accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        logic [15:0] held;
        logic [1:0]  pos;
        logic        sh;
        logic        stop;
        logic [23:0] grp;
        logic [5:0]  code;
        logic [2:0]  nch;

        held = i_item.start_label ? 16'h0000 : r_held;
        pos  = i_item.start_label ? 2'd0 : r_pos;
        sh   = i_item.start_label ? 1'b0 : r_shift;
        stop = 1'b0;
        nch  = 3'd0;
        grp  = {i_item.data_byte, held};
        code = 6'd0;
        job  = '0;
        n_held  = held;
        n_pos   = pos;
        n_shift = sh;
        n_done  = i_item.start_label ? 1'b0 : r_done;

        if (!n_done) begin
            case (pos)
                2'd0: begin
                    n_held = {held[15:8], i_item.data_byte};
                    n_pos  = 2'd1;
                end
                2'd1: begin
                    n_held = {i_item.data_byte, held[7:0]};
                    n_pos  = 2'd2;
                end
                default: begin
                    n_pos = 2'd0;
                    for (int i = 0; i < 4; i++) begin
                        code = grp[i*6 +: 6];
                        if (!stop) begin
                            if (code == CODE_TERM) begin
                                stop = 1'b1;
                                job.vld[MARK_SLOT] = 1'b1;
                            end else if (code == CODE_SHIFT) begin
                                sh = ~sh;
                            end else if (sh) begin
                                if (code < SYM_COUNT) begin
                                    job.vld[nch[1:0]] = 1'b1;
                                    job.chr[nch[1:0]] = f_symbol(code);
                                    nch = nch + 3'd1;
                                end
                            end else if (code == 6'd0) begin
                                job.vld[nch[1:0]] = 1'b1;
                                job.chr[nch[1:0]] = ASCII_SPACE;
                                nch = nch + 3'd1;
                            end else if (code <= CODE_ZLAST) begin
                                job.vld[nch[1:0]] = 1'b1;
                                job.chr[nch[1:0]] = {1'b0, code} + 7'd64;
                                nch = nch + 3'd1;
                            end else if (code >= CODE_D0 && code <= CODE_D9) begin
                                job.vld[nch[1:0]] = 1'b1;
                                job.chr[nch[1:0]] = {1'b0, code} + 7'd16;
                                nch = nch + 3'd1;
                            end
                        end
                    end
                    n_shift = sh;
                end
            endcase
            if (i_item.data_end)
                job.vld[MARK_SLOT] = 1'b1;
            if (job.vld[MARK_SLOT]) begin
                n_done = 1'b1;
                n_held = 16'h0000;
                n_pos  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pos   <= '0;
            r_shift <= 1'b0;
            r_done  <= 1'b0;
        end else if (accept) begin
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_done  <= n_done;
        end
    end

    assign o_q_wr  = accept && (|job.vld);
    assign o_q_job = job;

endmodule

/* design/sbl_fifo.sv */
// Job queue between front and back end. Uses sbl_pkg for the job type.
module sbl_fifo
    import sbl_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_job,
    input  logic i_rd,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr)
            r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr)
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            if (rd)
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
            if (wr && !rd)
                r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr)
                r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* design/sbl_back.sv */
// Back end: holds one job and hands out its results one per pop, oldest
// first, flagging the final one. Uses sbl_pkg.
module sbl_back
    import sbl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_q_job,
    input  logic    i_q_empty,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic [JOB_SLOTS-1:0]      r_vld, n_vld;
    logic [JOB_SLOTS-2:0][6:0] r_chr, n_chr;
    logic [JOB_SLOTS-1:0]      rem;
    logic                      last;
    logic                      take;

    assign rem     = r_vld & (r_vld - 1'b1);
    assign last    = (rem == '0);
    assign o_empty = (r_vld == '0);
    assign take    = i_pop && !o_empty;

    always_comb begin
        o_result = '0;
        o_result.last = last;
        if (r_vld[MARK_SLOT]) begin
            o_result.char_code = 7'd0;
            o_result.is_char   = 1'b0;
        end
        for (int i = MARK_SLOT - 1; i >= 0; i--) begin
            if (r_vld[i]) begin
                o_result.char_code = r_chr[i];
                o_result.is_char   = 1'b1;
            end
        end
    end

    always_comb begin
        n_vld  = r_vld;
        n_chr  = r_chr;
        o_q_rd = 1'b0;
        if (o_empty || (take && last)) begin
            if (!i_q_empty) begin
                n_vld  = i_q_job.vld;
                n_chr  = i_q_job.chr;
                o_q_rd = 1'b1;
            end else begin
                n_vld = '0;
            end
        end else if (take) begin
            n_vld = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else
            r_vld <= n_vld;
    end

    always_ff @(posedge i_clk) begin
        r_chr <= n_chr;
    end

endmodule

/* design/six_bit_label_decoder.sv */
// Top level of the six-bit packed label decoder.
// Connects sbl_front, sbl_fifo and sbl_back; uses sbl_pkg.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------
//   input   | in        | push / full       | i_item  (data_byte, start, end)
//   result  | out       | empty / pop       | o_result (char_code, is_char, last)
//
// One byte is taken per cycle while the job queue has room; each byte's
// results leave one per cycle while pop is held, so throughput is set by the result side:
// a byte with no results queues no job, and a byte that ends a group gives up to five.
// A taken byte's results pass through the job queue and then the back end's job
// register before they show on the result ports.
// Reset is synchronous; it clears group, shift and end state and empties the queue.
module six_bit_label_decoder
    import sbl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_item   i_item,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    logic q_wr, q_rd, q_full, q_empty;
    t_job q_in, q_out;

    sbl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_q_full(q_full),
        .o_full  (full),
        .o_q_wr  (q_wr),
        .o_q_job (q_in)
    );

    sbl_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_job  (q_in),
        .i_rd   (q_rd),
        .o_job  (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    sbl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_job  (q_out),
        .i_q_empty(q_empty),
        .o_q_rd   (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule
